// ===== hdl/hrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, character tables and limits for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int URI_MAX_DEF    = 128;
  localparam int MAX_DIGITS_DEF = 5;

  localparam int LEN_W = 17;
  localparam int ULEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_SAT = 17'h1FFFF;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_KEY_C = 8'h43;

  localparam logic [3:0] PROTO_LEN = 4'd8;
  localparam logic [3:0] KEY_LEN   = 4'd15;

  localparam logic [1:0] METH_NONE = 2'd0;
  localparam logic [1:0] METH_GET  = 2'd1;

  // method texts, upper case
  localparam logic [7:0] METH_TEXT [3][4] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54},
    '{8'h50, 8'h55, 8'h54, 8'h00}
  };
  localparam logic [3:0] METH_LEN [3] = '{4'd3, 4'd4, 4'd3};

  // HTTP/1.1
  localparam logic [7:0] PROTO_TEXT [8] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31
  };

  // Content-Length:
  localparam logic [7:0] KEY_TEXT [16] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h00
  };

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_SKIP1  = 3'd1,
    PH_URI    = 3'd2,
    PH_PROTO  = 3'd3,
    PH_SEARCH = 3'd4,
    PH_SKIP2  = 3'd5,
    PH_DIGITS = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        uri_byte;
    logic              accepted;
    logic [1:0]        method;
    logic [LEN_W-1:0]  content_length;
    logic [ULEN_W-1:0] uri_length;
  } out_item_t;

  // everything one input byte produces
  typedef struct packed {
    logic              has_uri;
    logic [7:0]        uri_byte;
    logic              has_sum;
    logic              accepted;
    logic [1:0]        method;
    logic [LEN_W-1:0]  content_length;
    logic [ULEN_W-1:0] uri_length;
  } outcome_t;

endpackage

// ===== hdl/http_request_line_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_line_parser
// Parses method, URI, protocol and Content-Length from a byte stream,
// emitting URI bytes as they arrive and a summary word on the final byte.
// ----------------------------------------------------------------------------
//  channel   direction  payload      handshake
//  in_       input      in_item_t    in_valid / in_stall
//  out_      output     out_item_t   out_valid / out_stall
//
//  one input word per cycle while in_stall is low; parse state is updated in the accepting cycle
//  outcomes go to a two-entry queue; results leave one word per cycle while out_stall is low
//  a final byte that is also a URI byte yields two words, the URI byte first, then the summary
//  in_stall rises only when the queue is full and its head is not leaving
//  rst_n clears parse state and the queue
// ----------------------------------------------------------------------------
module http_request_line_parser #(
  parameter int URI_MAX    = hrlp_pkg::URI_MAX_DEF,
  parameter int MAX_DIGITS = hrlp_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrlp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrlp_pkg::out_item_t out_data
);
  import hrlp_pkg::*;

  localparam int UCW = $clog2(URI_MAX);
  localparam int DCW = (MAX_DIGITS < 2) ? 1 : $clog2(MAX_DIGITS + 1);
  localparam logic [UCW-1:0] URI_LIM = UCW'(URI_MAX - 1);
  localparam logic [DCW-1:0] DIG_LIM = DCW'(MAX_DIGITS);

  phase_t           phase_r, phase_nxt;
  logic [3:0]       match_idx_r, match_idx_nxt;
  logic [1:0]       method_r, method_nxt;
  logic [2:0]       cand_r, cand_nxt;
  logic [UCW-1:0]   uri_cnt_r, uri_cnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [DCW-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic             failed_r, failed_nxt;

  outcome_t         fifo_r [2];
  logic             wr_ptr_r, rd_ptr_r, sub_r;
  logic [1:0]       cnt_r;

  logic [7:0]       b, up;
  logic             is_digit, emit, in_acc, out_acc, push, pop_entry, show_uri;
  logic [2:0]       live;
  logic [1:0]       done;
  logic [20:0]      prod;
  logic [UCW-1:0]   uri_inc;
  logic [DCW-1:0]   dig_inc;
  logic [UCW+6:0]   uri_ext;
  logic             parsed;
  outcome_t         ent, head;

  assign b        = in_data.data_byte;
  assign up       = (b >= CH_LC_A && b <= CH_LC_Z) ? (b - 8'h20) : b;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign prod     = ({4'b0, len_r} * 21'd10) + {17'b0, b[3:0]};
  assign uri_inc  = uri_cnt_r + UCW'(1);
  assign dig_inc  = dig_cnt_r + DCW'(1);

  always_comb begin
    live = 3'b000;
    done = METH_NONE;
    for (int c = 0; c < 3; c++) begin
      if (cand_r[c] && match_idx_r < METH_LEN[c] &&
          up == METH_TEXT[c][match_idx_r[1:0]]) begin
        if (match_idx_r + 4'd1 == METH_LEN[c]) begin
          done = 2'(c + 1);
        end else begin
          live[c] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    match_idx_nxt = match_idx_r;
    method_nxt    = method_r;
    cand_nxt      = cand_r;
    uri_cnt_nxt   = uri_cnt_r;
    len_nxt       = len_r;
    dig_cnt_nxt   = dig_cnt_r;
    failed_nxt    = failed_r;
    emit          = 1'b0;

    if (!failed_r) begin
      unique case (phase_r)
        PH_METHOD: begin
          if (done != METH_NONE) begin
            method_nxt    = done;
            match_idx_nxt = 4'd0;
            phase_nxt     = PH_SKIP1;
          end else if (live == 3'b000) begin
            failed_nxt = 1'b1;
          end else begin
            cand_nxt      = live;
            match_idx_nxt = match_idx_r + 4'd1;
          end
        end
        PH_SKIP1, PH_URI: begin
          if (b == CH_SPACE) begin
            if (phase_r == PH_URI) begin
              phase_nxt = PH_PROTO;
            end
          end else if (phase_r == PH_URI || b == CH_SLASH) begin
            emit        = 1'b1;
            uri_cnt_nxt = uri_inc;
            phase_nxt   = (uri_inc >= URI_LIM) ? PH_PROTO : PH_URI;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_PROTO: begin
          if (match_idx_r < PROTO_LEN && b == PROTO_TEXT[match_idx_r[2:0]]) begin
            if (match_idx_r + 4'd1 == PROTO_LEN) begin
              match_idx_nxt = 4'd0;
              phase_nxt     = PH_SEARCH;
            end else begin
              match_idx_nxt = match_idx_r + 4'd1;
            end
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_SEARCH: begin
          if (match_idx_r < KEY_LEN && b == KEY_TEXT[match_idx_r]) begin
            if (match_idx_r + 4'd1 == KEY_LEN) begin
              match_idx_nxt = 4'd0;
              phase_nxt     = PH_SKIP2;
            end else begin
              match_idx_nxt = match_idx_r + 4'd1;
            end
          end else begin
            match_idx_nxt = (b == CH_KEY_C) ? 4'd1 : 4'd0;
          end
        end
        PH_SKIP2, PH_DIGITS: begin
          if (is_digit) begin
            len_nxt     = (prod > {4'b0, LEN_SAT}) ? LEN_SAT : prod[LEN_W-1:0];
            dig_cnt_nxt = dig_inc;
            phase_nxt   = (dig_inc >= DIG_LIM) ? PH_DONE : PH_DIGITS;
          end else if (!(phase_r == PH_SKIP2 && b == CH_SPACE)) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    uri_ext = {7'b0, uri_cnt_nxt};
    parsed  = !failed_nxt && (phase_nxt >= PH_SEARCH);

    ent.has_uri        = emit;
    ent.uri_byte       = b;
    ent.has_sum        = in_data.last_byte;
    ent.accepted       = parsed && (method_nxt == METH_GET || len_nxt != '0);
    ent.method         = method_nxt;
    ent.content_length = len_nxt;
    ent.uri_length     = uri_ext[ULEN_W-1:0];

    if (in_data.last_byte) begin
      phase_nxt     = PH_METHOD;
      match_idx_nxt = 4'd0;
      method_nxt    = METH_NONE;
      cand_nxt      = 3'b111;
      uri_cnt_nxt   = '0;
      len_nxt       = '0;
      dig_cnt_nxt   = '0;
      failed_nxt    = 1'b0;
    end
  end

  // output queue
  assign head      = fifo_r[rd_ptr_r];
  assign show_uri  = head.has_uri && !sub_r;
  assign out_valid = (cnt_r != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  assign pop_entry = out_acc && (!show_uri || !head.has_sum);
  assign in_stall  = (cnt_r == 2'd2) && !pop_entry;
  assign in_acc    = in_valid && !in_stall;
  assign push      = in_acc && (emit || in_data.last_byte);

  always_comb begin
    out_data.kind           = !show_uri;
    out_data.uri_byte       = show_uri ? head.uri_byte : 8'd0;
    out_data.accepted       = show_uri ? 1'b0 : head.accepted;
    out_data.method         = show_uri ? METH_NONE : head.method;
    out_data.content_length = show_uri ? '0 : head.content_length;
    out_data.uri_length     = show_uri ? '0 : head.uri_length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_METHOD;
      match_idx_r <= 4'd0;
      method_r    <= METH_NONE;
      cand_r      <= 3'b111;
      uri_cnt_r   <= '0;
      len_r       <= '0;
      dig_cnt_r   <= '0;
      failed_r    <= 1'b0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      match_idx_r <= match_idx_nxt;
      method_r    <= method_nxt;
      cand_r      <= cand_nxt;
      uri_cnt_r   <= uri_cnt_nxt;
      len_r       <= len_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      failed_r    <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      sub_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_entry) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (out_acc) begin
        sub_r <= !pop_entry;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop_entry};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= ent;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_sub_head: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (cnt_r != 2'd0) && head.has_uri && head.has_sum)
    else $error("split flag set without a two-word head entry");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_byte) |=>
      (phase_r == PH_METHOD) && (match_idx_r == 4'd0) && !failed_r &&
      (uri_cnt_r == '0) && (len_r == '0))
    else $error("parse state not cleared after final byte");

  a_dig_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dig_cnt_r <= DIG_LIM)
    else $error("digit count beyond limit");

  a_uri_bound: assert property (@(posedge clk) disable iff (!rst_n)
    uri_cnt_r <= URI_LIM)
    else $error("uri count beyond limit");
`endif

endmodule
